// ===== sv/sorted_id_table_lookup_with_fallback_macros.svh =====
// Assertion macros for the sorted id table lookup block.
`ifndef SORTED_ID_TABLE_LOOKUP_WITH_FALLBACK_MACROS_SVH
`define SORTED_ID_TABLE_LOOKUP_WITH_FALLBACK_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SITL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SITL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sitl_pkg.sv =====
// Package with types and constants of the sorted id table lookup block.
`timescale 1ns / 1ps

package sitl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ID_BITS     = 24;
    localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = SLOT_BITS + 1;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [SLOT_BITS-1:0] entry_slot;
        logic [ID_BITS-1:0]   id_value;
        logic                 catch_all_flag;
    } request_t;

    typedef struct packed {
        logic                 exact_hit;
        logic [SLOT_BITS-1:0] exact_slot;
        logic                 fallback_valid;
        logic [SLOT_BITS-1:0] fallback_slot;
    } result_t;

    typedef struct packed {
        logic               catch_all;
        logic [ID_BITS-1:0] id;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BS_RD,
        ST_BS_EV,
        ST_BK_RD,
        ST_BK_EV,
        ST_CHK,
        ST_CA_RD,
        ST_CA_EV,
        ST_FB_RD,
        ST_FB_EV
    } state_t;

endpackage

// ===== sv/sorted_id_table_lookup_with_fallback.sv =====
// Sorted id table with binary search, first-occurrence step back and catch-all fallback.
// Write item: taken while idle, busy stays low; a write gives no result.
// Lookup: table reads on a single-port memory with a registered read: binary search probes
//   (up to floor(log2(n))+1), step-back reads, on a key match a check and maybe a catch-all
//   read, scanned entries, then the result register; next item taken in strobe cycle.
// Empty table answers the next cycle. Reset clears the count and the control state only.
`timescale 1ns / 1ps
`include "sorted_id_table_lookup_with_fallback_macros.svh"

module sorted_id_table_lookup_with_fallback
    import sitl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  request_t            request,
    output logic                done,
    output result_t             result,
    input  logic                cfg_wr_en,
    input  logic [CNT_BITS-1:0] cfg_wr_data
);

    // Table memory: one entry per slot, synchronous read into a registered output.
    entry_t               mem [TABLE_DEPTH];
    entry_t               rd_data_reg;
    logic                 rd_en;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 wr_en;

    state_t               state_reg, state_next;
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_sat;
    logic [ID_BITS-1:0]   key_reg, key_next;
    logic [CNT_BITS-1:0]  n_reg, n_next;
    logic [CNT_BITS-1:0]  lo_reg, lo_next;
    logic [CNT_BITS-1:0]  hix_reg, hix_next;     // exclusive upper bound of the window
    logic [SLOT_BITS-1:0] cur_reg, cur_next;
    logic                 cur_ca_reg, cur_ca_next;
    logic                 hit_reg, hit_next;
    logic [SLOT_BITS-1:0] hit_slot_reg, hit_slot_next;
    logic [SLOT_BITS-1:0] fb_reg, fb_next;
    logic [SLOT_BITS-1:0] scan_reg, scan_next;
    logic                 done_reg, done_next;
    result_t              result_reg, result_next;

    logic                 accept;
    logic                 lookup_go;
    logic                 empty;
    logic [CNT_BITS:0]    mid_sum;
    logic [SLOT_BITS-1:0] mid;
    logic                 key_eq, key_lt;
    logic [CNT_BITS-1:0]  lo_upd, hix_upd;
    logic                 bs_more;
    logic [SLOT_BITS-1:0] cur_dec;
    logic [CNT_BITS-1:0]  cur_inc;
    logic                 scan_last;
    logic                 scan_stop;
    logic [CNT_BITS-1:0]  hit_slot_wide;

    // ------------------------------------------------------------------
    // Shared decode
    // ------------------------------------------------------------------
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign lookup_go = accept && (request.req_type == REQ_LOOKUP);

    // Clamp the configured count to the table depth.
    assign count_sat = (count_reg > CNT_BITS'(TABLE_DEPTH)) ? CNT_BITS'(TABLE_DEPTH) : count_reg;
    assign empty     = (count_sat == '0);

    // Midpoint of [lo, hix-1]; the window is nonempty whenever it is used.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hix_reg} - (CNT_BITS+1)'(1);
    assign mid     = mid_sum[SLOT_BITS:1];

    assign key_eq  = (rd_data_reg.id == key_reg);
    assign key_lt  = (key_reg < rd_data_reg.id);
    assign lo_upd  = key_lt ? lo_reg : ({1'b0, mid} + CNT_BITS'(1));
    assign hix_upd = key_lt ? {1'b0, mid} : hix_reg;
    assign bs_more = (lo_upd < hix_upd);

    assign cur_dec = cur_reg - SLOT_BITS'(1);
    assign cur_inc = {1'b0, cur_reg} + CNT_BITS'(1);

    // Fallback scan ends at the first id at or above the key, or at the last entry.
    assign scan_last = ({1'b0, scan_reg} == (n_reg - CNT_BITS'(1)));
    assign scan_stop = (rd_data_reg.id >= key_reg) || scan_last;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (lookup_go && !empty)
                begin
                    state_next = ST_BS_RD;
                end
            end
            ST_BS_RD:
            begin
                state_next = ST_BS_EV;
            end
            ST_BS_EV:
            begin
                if (key_eq)
                begin
                    state_next = (mid != '0) ? ST_BK_RD : ST_CHK;
                end
                else
                begin
                    state_next = bs_more ? ST_BS_RD : ST_FB_RD;
                end
            end
            ST_BK_RD:
            begin
                state_next = ST_BK_EV;
            end
            ST_BK_EV:
            begin
                if (key_eq && (cur_dec != '0))
                begin
                    state_next = ST_BK_RD;
                end
                else
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (cur_ca_reg && (cur_inc < n_reg))
                begin
                    state_next = ST_CA_RD;
                end
                else
                begin
                    state_next = ST_FB_RD;
                end
            end
            ST_CA_RD:
            begin
                state_next = ST_CA_EV;
            end
            ST_CA_EV:
            begin
                state_next = ST_FB_RD;
            end
            ST_FB_RD:
            begin
                state_next = ST_FB_EV;
            end
            ST_FB_EV:
            begin
                state_next = scan_stop ? ST_IDLE : ST_FB_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory control
    // ------------------------------------------------------------------
    always_comb
    begin
        key_next      = key_reg;
        n_next        = n_reg;
        lo_next       = lo_reg;
        hix_next      = hix_reg;
        cur_next      = cur_reg;
        cur_ca_next   = cur_ca_reg;
        hit_next      = hit_reg;
        hit_slot_next = hit_slot_reg;
        fb_next       = fb_reg;
        scan_next     = scan_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        rd_en         = 1'b0;
        rd_addr       = mid;
        // The slot field cannot exceed the table, so every write lands.
        wr_en         = accept && (request.req_type == REQ_WRITE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (lookup_go)
                begin
                    key_next  = request.id_value;
                    n_next    = count_sat;
                    lo_next   = '0;
                    hix_next  = count_sat;
                    hit_next  = 1'b0;
                    fb_next   = '0;
                    scan_next = '0;
                    if (empty)
                    begin
                        // Answer an empty table at once.
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                end
            end
            ST_BS_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = mid;
            end
            ST_BS_EV:
            begin
                if (key_eq)
                begin
                    cur_next    = mid;
                    cur_ca_next = rd_data_reg.catch_all;
                end
                else
                begin
                    lo_next  = lo_upd;
                    hix_next = hix_upd;
                end
            end
            ST_BK_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = cur_dec;
            end
            ST_BK_EV:
            begin
                // Step back while the previous entry still carries the key.
                if (key_eq)
                begin
                    cur_next    = cur_dec;
                    cur_ca_next = rd_data_reg.catch_all;
                end
            end
            ST_CHK:
            begin
                if (!cur_ca_reg)
                begin
                    hit_next      = 1'b1;
                    hit_slot_next = cur_reg;
                end
                else
                begin
                    // Catch-all at the last valid entry gives no hit.
                    hit_next = 1'b0;
                end
            end
            ST_CA_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = cur_inc[SLOT_BITS-1:0];
            end
            ST_CA_EV:
            begin
                hit_next      = key_eq;
                hit_slot_next = cur_inc[SLOT_BITS-1:0];
            end
            ST_FB_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = scan_reg;
            end
            ST_FB_EV:
            begin
                if (rd_data_reg.catch_all)
                begin
                    fb_next = scan_reg;
                end
                if (scan_stop)
                begin
                    done_next                  = 1'b1;
                    result_next.exact_hit      = hit_reg;
                    result_next.exact_slot     = hit_reg ? hit_slot_reg : '0;
                    result_next.fallback_valid = 1'b1;
                    result_next.fallback_slot  = rd_data_reg.catch_all ? scan_reg : fb_reg;
                end
                else
                begin
                    scan_next = scan_reg + SLOT_BITS'(1);
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Table memory
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[request.entry_slot] <= '{catch_all: request.catch_all_flag,
                                         id: request.id_value};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        n_reg        <= n_next;
        lo_reg       <= lo_next;
        hix_reg      <= hix_next;
        cur_reg      <= cur_next;
        cur_ca_reg   <= cur_ca_next;
        hit_reg      <= hit_next;
        hit_slot_reg <= hit_slot_next;
        fb_reg       <= fb_next;
        scan_reg     <= scan_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Widen the reported slot to the count width for the range check.
    assign hit_slot_wide = {1'b0, result.exact_slot};

    `SITL_ASSERT_NOW(a_done_when_idle, done, !busy, "result strobe while a lookup is in flight")
    `SITL_ASSERT_NEXT(a_write_no_result, wr_en, !done, "write item produced a result")
    `SITL_ASSERT_NOW(a_miss_slot_zero, done && !result.exact_hit, result.exact_slot == '0,
                     "exact slot not zero on a miss")
    `SITL_ASSERT_NOW(a_hit_in_range, done && result.exact_hit, hit_slot_wide < count_sat,
                     "exact slot beyond valid entries")

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the sorted id table lookup block.
`timescale 1ns / 1ps

module testbench;
    import sitl_pkg::*;

    // Run limits: the slowest legal run stays far below this many cycles.
    localparam int unsigned CYCLE_LIMIT = 5_000_000;
    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned MAX_PRINTED = 40;
    localparam logic [ID_BITS-1:0] ID_MAX = {ID_BITS{1'b1}};

    // Predictor and store of expected lookup answers. The monitor feeds it every
    // accepted item and every result strobe; it mirrors the table and the count.
    class lookup_scoreboard;
        logic [ID_BITS-1:0] ids[TABLE_DEPTH];
        bit                 catch_all[TABLE_DEPTH];
        int unsigned        entry_count;
        result_t            pending_answers[$];
        int unsigned        mismatches;
        int unsigned        lookups_checked;
        int unsigned        exact_hits;
        int unsigned        writes_seen;

        function new();
            entry_count = 0;
            mismatches = 0;
            lookups_checked = 0;
            exact_hits = 0;
            writes_seen = 0;
        endfunction

        task report(input string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        function void set_count(input logic [CNT_BITS-1:0] value);
            entry_count = value;
        endfunction

        // Binary search stepping back to the first equal id, then the catch-all
        // skip, then the linear fallback scan over the valid entries.
        function result_t predict_lookup(input logic [ID_BITS-1:0] key);
            result_t answer;
            int      n;
            int      lo;
            int      hi;
            int      mid;
            int      fb;
            bit      found;
            answer = '0;
            found = 1'b0;
            n = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
            lo = 0;
            hi = n - 1;
            while (lo <= hi && !found)
            begin
                mid = (lo + hi) / 2;
                if (ids[mid] == key)
                begin
                    found = 1'b1;
                    while (mid > 0 && ids[mid - 1] == key)
                        mid--;
                    // Skip a catch-all; the next entry must carry the same id.
                    if (catch_all[mid])
                        mid++;
                    if (mid < n && ids[mid] == key)
                    begin
                        answer.exact_hit = 1'b1;
                        answer.exact_slot = SLOT_BITS'(mid);
                    end
                end
                else if (key < ids[mid])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
            if (n > 0)
            begin
                fb = 0;
                for (int i = 0; i < n; i++)
                begin
                    if (catch_all[i])
                        fb = i;
                    if (ids[i] >= key)
                        break;
                end
                answer.fallback_valid = 1'b1;
                answer.fallback_slot = SLOT_BITS'(fb);
            end
            return answer;
        endfunction

        task note_request(input request_t req);
            if (req.req_type == REQ_WRITE)
            begin
                ids[req.entry_slot] = req.id_value;
                catch_all[req.entry_slot] = req.catch_all_flag;
                writes_seen++;
            end
            else
                pending_answers.push_back(predict_lookup(req.id_value));
        endtask

        task check_result(input result_t got);
            result_t want;
            if (pending_answers.size() == 0)
            begin
                report($sformatf("result with no lookup waiting: %h", got));
                return;
            end
            want = pending_answers.pop_front();
            lookups_checked++;
            if (want.exact_hit)
                exact_hits++;
            if (got.exact_hit !== want.exact_hit)
                report($sformatf("exact_hit %b, want %b", got.exact_hit, want.exact_hit));
            if (got.exact_slot !== want.exact_slot)
                report($sformatf("exact_slot %0d, want %0d", got.exact_slot, want.exact_slot));
            if (got.fallback_valid !== want.fallback_valid)
                report($sformatf("fallback_valid %b, want %b",
                                 got.fallback_valid, want.fallback_valid));
            if (got.fallback_slot !== want.fallback_slot)
                report($sformatf("fallback_slot %0d, want %0d",
                                 got.fallback_slot, want.fallback_slot));
        endtask
    endclass

    // Clock, reset and block inputs; every input holds a known value from time 0.
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    request_t            request = '0;
    logic                done;
    result_t             result;
    logic                cfg_wr_en = 1'b0;
    logic [CNT_BITS-1:0] cfg_wr_data = '0;

    lookup_scoreboard    sb = new();
    int unsigned         cycles = 0;
    int unsigned         count_settings = 0;
    int unsigned         random_items = 0;
    bit                  burst_mode = 1'b0;

    sorted_id_table_lookup_with_fallback dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Monitor: check the result strobe first, then note the item taken at this
    // edge, so a result never pairs with a lookup accepted in the same cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_request(request);
        end
    end

    // Watchdog: a hung handshake or lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d lookups still waiting",
                     cycles, sb.pending_answers.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // Gap after an item: none in burst mode; else mostly none, sometimes short, rarely a long pause.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (burst_mode)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Present one item and hold it until the block takes it. Keep start high
    // when the next item follows back to back; drop it only for a gap.
    task automatic send_item(input request_t req);
        int unsigned gap;
        request <= req;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_entry(input int unsigned slot, input logic [ID_BITS-1:0] id,
                               input bit flag);
        request_t req;
        req.req_type = REQ_WRITE;
        req.entry_slot = SLOT_BITS'(slot);
        req.id_value = id;
        req.catch_all_flag = flag;
        send_item(req);
    endtask

    // The slot and flag fields are ignored on a lookup; fill them with noise.
    task automatic lookup(input logic [ID_BITS-1:0] key);
        request_t req;
        req.req_type = REQ_LOOKUP;
        req.entry_slot = SLOT_BITS'($urandom_range(0, TABLE_DEPTH - 1));
        req.id_value = key;
        req.catch_all_flag = $urandom_range(0, 1);
        send_item(req);
    endtask

    // Wait until every lookup answer is in and the block is idle, then wait out a
    // margin, since a write leaves nothing to wait on.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_answers.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_count(input int unsigned value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= CNT_BITS'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_count(CNT_BITS'(value));
        count_settings++;
    endtask

    // Load slots 0..n-1 with ascending ids: duplicates, small steps, rare jumps,
    // saturating at the top id so that runs of the maximum also show up.
    task automatic fill_table(input int unsigned n, input logic [ID_BITS-1:0] base,
                              input int unsigned max_step);
        logic [ID_BITS:0] id;
        int unsigned      roll;
        id = {1'b0, base};
        for (int unsigned i = 0; i < n; i++)
        begin
            write_entry(i, id[ID_BITS-1:0], $urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 9);
            if (roll >= 3 && roll < 9)
                id = id + $urandom_range(1, max_step);
            else if (roll == 9)
                id = id + $urandom_range(1, 1 << 20);
            if (id > ID_MAX)
                id = {1'b0, ID_MAX};
        end
    endtask

    // Keys: mostly ids that are in the table, some neighbors, some anywhere.
    function automatic logic [ID_BITS-1:0] pick_key(input int unsigned n);
        int unsigned        roll;
        logic [ID_BITS-1:0] id;
        roll = $urandom_range(0, 99);
        if (n == 0 || roll >= 80)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return ID_MAX;
                default: return $urandom_range(0, ID_MAX);
            endcase
        end
        id = sb.ids[$urandom_range(0, n - 1)];
        if (roll < 55)
            return id;
        else if (roll < 68)
            return id + 1'b1;
        else
            return id - 1'b1;
    endfunction

    initial
    begin
        int unsigned n;
        int unsigned count;
        int unsigned roll;
        int unsigned round_items;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table right after reset: nothing is read, both answers are zero.
        lookup('0);
        lookup(ID_MAX);

        // Small hand-built table: catch-all at the front, duplicate ids, a
        // catch-all followed by an equal id, a catch-all followed by a larger id,
        // and a catch-all as the last valid entry.
        write_entry(0, 24'd0, 1'b1);
        write_entry(1, 24'd5, 1'b0);
        write_entry(2, 24'd5, 1'b0);
        write_entry(3, 24'd9, 1'b1);
        write_entry(4, 24'd9, 1'b0);
        write_entry(5, 24'd12, 1'b1);
        write_entry(6, 24'd20, 1'b0);
        write_entry(7, ID_MAX, 1'b1);
        set_count(8);
        lookup(24'd0);
        lookup(24'd5);
        lookup(24'd9);
        lookup(24'd12);
        lookup(24'd20);
        lookup(ID_MAX);
        lookup(24'd3);
        lookup(24'd13);
        set_count(7);
        lookup(ID_MAX);
        set_count(1);
        lookup(24'd0);

        // Whole table: every slot written, then the full count, a count above
        // the depth that must saturate, and zero over a populated table.
        fill_table(TABLE_DEPTH, $urandom_range(0, 1000), 9000);
        set_count(TABLE_DEPTH);
        lookup('0);
        lookup(ID_MAX);
        lookup(sb.ids[TABLE_DEPTH - 1]);
        repeat (3) lookup(pick_key(TABLE_DEPTH));
        set_count((1 << CNT_BITS) - 1);
        lookup(ID_MAX);
        repeat (3) lookup(pick_key(TABLE_DEPTH));
        set_count(0);
        lookup(pick_key(0));

        // Random rounds: mostly reload a sorted table (sometimes spoiled by stray
        // writes), pick a count, then mostly lookups with a few writes mixed in.
        // All slots hold data by now, so any count reads only written entries.
        while (random_items < RANDOM_ITEMS)
        begin
            burst_mode = ($urandom_range(0, 4) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 8)
                n = $urandom_range(100, TABLE_DEPTH);
            else if (roll < 12)
                n = 0;
            else
                n = $urandom_range(1, 40);
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 4) == 0)
                    fill_table(n, ID_MAX - $urandom_range(0, 64), 4);
                else
                    fill_table(n, $urandom_range(0, ID_MAX / 2), $urandom_range(1, 5000));
            end
            if (n > 0 && $urandom_range(0, 99) < 15)
                repeat (3)
                    write_entry($urandom_range(0, n - 1), $urandom_range(0, ID_MAX),
                                $urandom_range(0, 1));
            roll = $urandom_range(0, 19);
            if (roll == 0)
                count = $urandom_range(TABLE_DEPTH + 1, (1 << CNT_BITS) - 1);
            else if (roll == 1)
                count = $urandom_range(0, TABLE_DEPTH);
            else
                count = n;
            set_count(count);
            if (count > TABLE_DEPTH)
                count = TABLE_DEPTH;
            // Keep rounds over long tables short: each lookup scans far.
            round_items = (count > 64) ? $urandom_range(4, 10) : $urandom_range(20, 40);
            for (int unsigned i = 0; i < round_items; i++)
            begin
                if ($urandom_range(0, 99) < 15)
                    write_entry($urandom_range(0, TABLE_DEPTH - 1),
                                $urandom_range(0, ID_MAX), $urandom_range(0, 1));
                else
                    lookup(pick_key(count));
                random_items++;
            end
        end

        // Let the last answers come in, then allow for the block's latency.
        burst_mode = 1'b0;
        drain();
        repeat (50) @(posedge clk);

        if (sb.pending_answers.size() != 0)
            sb.report($sformatf("%0d lookups never answered", sb.pending_answers.size()));

        $display("covered %0d lookups (%0d exact hits) and %0d table writes",
                 sb.lookups_checked, sb.exact_hits, sb.writes_seen);
        $display("over %0d count settings, empty through saturated, in %0d cycles",
                 count_settings, cycles);
        if (sb.mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
